FILE: hw/rtl/two_sensor_kalman_fusion_defines.svh
// Assertion macros shared by the fusion block.
`ifndef TWO_SENSOR_KALMAN_FUSION_DEFINES_SVH
`define TWO_SENSOR_KALMAN_FUSION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tskf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TSKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tskf: next-cycle check failed");

`endif

FILE: hw/rtl/tskf_pkg.sv
`timescale 1ns / 1ps

package tskf_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 16;
    localparam int WEIGHT_BITS = 8;
    localparam int NOISE_BITS  = 16;
    localparam int VAR_BITS    = 17;   // P in Q1.16
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Divider geometry: 33-bit dividend, 18-bit divisor
    localparam int DIV_NUM_BITS = 33;
    localparam int DIV_DEN_BITS = 18;
    localparam int DIV_CNT_BITS = 6;
    localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS_WEIGHTED = 6'd26;
    localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS_GAIN     = 6'd33;

    // Unity gain in Q1.16
    localparam logic [VAR_BITS-1:0] GAIN_ONE = 17'h10000;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT_FIRST   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT_SECOND  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOISE_VARIANCE = 2'd2;

    // Reset values (0.79, 0.92, 0.1)
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_FIRST_RST  = 8'd202;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_SECOND_RST = 8'd235;
    localparam logic [NOISE_BITS-1:0]  NOISE_RST         = 16'd6554;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample_first;
        t_sample sample_second;
    } t_in_item;

    typedef struct packed {
        t_sample mean_value;
        t_sample weighted_value;
        t_sample filtered_value;
    } t_out_item;

    // Divider control and status
    typedef struct packed {
        logic                    start;
        logic [DIV_CNT_BITS-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Clamp a 21-bit signed value to the sample range
    function automatic t_sample sat_sample(input logic signed [20:0] v);
        logic signed [20:0] hi;
        logic signed [20:0] lo;
        hi = 21'sd32767;
        lo = -21'sd32768;
        if (v > hi) begin
            return 16'sh7FFF;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/tskf_div.sv
`timescale 1ns / 1ps

module tskf_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tskf_pkg::t_div_req                    i_req,
    input  logic [tskf_pkg::DIV_NUM_BITS-1:0]     i_num,
    input  logic [tskf_pkg::DIV_DEN_BITS-1:0]     i_den,
    output tskf_pkg::t_div_stat                   o_stat,
    output logic [tskf_pkg::DIV_NUM_BITS-1:0]     o_quot
);
    import tskf_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DIV_NUM_BITS-1:0] r_num;   // dividend bits out, quotient bits in
    logic [DIV_DEN_BITS-1:0] r_rem;
    logic [DIV_DEN_BITS-1:0] r_den;

    logic [DIV_DEN_BITS:0]   trial;
    logic [DIV_DEN_BITS:0]   diff;
    logic                    take;

    // One restoring step per cycle, dividend taken msb first
    always_comb begin
        trial = {r_rem, r_num[DIV_NUM_BITS-1]};
        diff  = trial - {1'b0, r_den};
        take  = (trial >= {1'b0, r_den});
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_BITS-2:0], take};
            r_rem <= take ? diff[DIV_DEN_BITS-1:0] : trial[DIV_DEN_BITS-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_num;

endmodule

FILE: hw/rtl/two_sensor_kalman_fusion.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction in gives one result; both weights zero skips the weighted
// divide, and P+R zero skips the gain divide. The block has a single serial
// divider and one shared 18x18 multiplier used four times. Input stall is high,
// config ready low, in reset and until the result is parked.
// Reset (synchronous, active low) sets weights 202/235, R 6554, estimate 0, P 1.0.
// A stalled result holds in the output register while the next transaction waits.
`timescale 1ns / 1ps
`include "two_sensor_kalman_fusion_defines.svh"

module two_sensor_kalman_fusion (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  tskf_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output tskf_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tskf_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [tskf_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import tskf_pkg::*;

    // Sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_A  = 4'd1;
    localparam logic [3:0] S_MUL_B  = 4'd2;
    localparam logic [3:0] S_WSTART = 4'd3;
    localparam logic [3:0] S_WDIV   = 4'd4;
    localparam logic [3:0] S_GSTART = 4'd5;
    localparam logic [3:0] S_GDIV   = 4'd6;
    localparam logic [3:0] S_MUL_K  = 4'd7;
    localparam logic [3:0] S_MUL_P  = 4'd8;
    localparam logic [3:0] S_UPD    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0]               r_state;
    logic [3:0]               n_state;
    logic [WEIGHT_BITS-1:0]   r_wf;
    logic [WEIGHT_BITS-1:0]   r_ws;
    logic [NOISE_BITS-1:0]    r_noise;
    t_sample                  r_estimate;
    logic [VAR_BITS-1:0]      r_var;
    t_in_item                 r_in;
    t_sample                  r_mean;
    t_sample                  r_weighted;
    logic signed [24:0]       r_acc;
    logic signed [35:0]       r_prod;
    logic [VAR_BITS-1:0]      r_gain;
    logic                     r_neg;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic                     in_take;
    logic                     out_free;
    logic signed [16:0]       pair_sum;
    logic [WEIGHT_BITS:0]     wsum;
    logic signed [25:0]       wnum;
    logic [25:0]              wmag;
    logic [DIV_DEN_BITS-1:0]  gden;
    logic signed [16:0]       diff;
    logic [VAR_BITS-1:0]      one_minus;
    logic signed [20:0]       est_sum;
    logic signed [17:0]       mul_a;
    logic signed [17:0]       mul_b;
    logic signed [35:0]       product;
    t_div_req                 div_req;
    t_div_stat                div_stat;
    logic [DIV_NUM_BITS-1:0]  div_num;
    logic [DIV_DEN_BITS-1:0]  div_den;
    logic [DIV_NUM_BITS-1:0]  div_quot;

    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Datapath terms
    always_comb begin
        pair_sum  = {i_in_data.sample_first[SAMPLE_BITS-1], i_in_data.sample_first}
                  + {i_in_data.sample_second[SAMPLE_BITS-1], i_in_data.sample_second};
        wsum      = {1'b0, r_wf} + {1'b0, r_ws};
        wnum      = {r_acc[24], r_acc} + r_prod[25:0];
        wmag      = wnum[25] ? ~wnum : wnum;
        gden      = {1'b0, r_var} + {2'b0, r_noise};
        diff      = {r_weighted[SAMPLE_BITS-1], r_weighted}
                  - {r_estimate[SAMPLE_BITS-1], r_estimate};
        one_minus = GAIN_ONE - r_gain;
        est_sum   = {{5{r_estimate[SAMPLE_BITS-1]}}, r_estimate}
                  + {r_prod[35], r_prod[35:16]};
    end

    // Shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_MUL_A: begin
                mul_a = {10'b0, r_wf};
                mul_b = {{2{r_in.sample_first[SAMPLE_BITS-1]}}, r_in.sample_first};
            end
            S_MUL_B: begin
                mul_a = {10'b0, r_ws};
                mul_b = {{2{r_in.sample_second[SAMPLE_BITS-1]}}, r_in.sample_second};
            end
            S_MUL_K: begin
                mul_a = {1'b0, r_gain};
                mul_b = {diff[16], diff};
            end
            S_MUL_P: begin
                mul_a = {1'b0, one_minus};
                mul_b = {1'b0, r_var};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = mul_a * mul_b;
    end

    // Divider requests: weighted mean, then gain
    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = DIV_STEPS_GAIN;
        div_num       = {r_var, 16'b0};
        div_den       = gden;
        if (r_state == S_WSTART) begin
            div_req.start = (wsum != '0);
            div_req.steps = DIV_STEPS_WEIGHTED;
            div_num       = {wmag, 7'b0};
            div_den       = {{(DIV_DEN_BITS-WEIGHT_BITS-1){1'b0}}, wsum};
        end else if (r_state == S_GSTART) begin
            div_req.start = (gden != '0);
        end
    end

    tskf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_take) n_state = S_MUL_A;
            S_MUL_A:  n_state = S_MUL_B;
            S_MUL_B:  n_state = S_WSTART;
            S_WSTART: n_state = (wsum != '0) ? S_WDIV : S_GSTART;
            S_WDIV:   if (div_stat.done) n_state = S_GSTART;
            S_GSTART: n_state = (gden != '0) ? S_GDIV : S_MUL_K;
            S_GDIV:   if (div_stat.done) n_state = S_MUL_K;
            S_MUL_K:  n_state = S_MUL_P;
            S_MUL_P:  n_state = S_UPD;
            S_UPD:    n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state, filter state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wf        <= WEIGHT_FIRST_RST;
            r_ws        <= WEIGHT_SECOND_RST;
            r_noise     <= NOISE_RST;
            r_estimate  <= '0;
            r_var       <= GAIN_ONE;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_WEIGHT_FIRST:   r_wf    <= i_cfg_data[WEIGHT_BITS-1:0];
                    CFG_WEIGHT_SECOND:  r_ws    <= i_cfg_data[WEIGHT_BITS-1:0];
                    CFG_NOISE_VARIANCE: r_noise <= i_cfg_data[NOISE_BITS-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_MUL_P) begin
                r_estimate <= sat_sample(est_sum);
            end
            if (r_state == S_UPD) begin
                r_var <= r_prod[32:16];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= product;
        if (in_take) begin
            r_in   <= i_in_data;
            r_mean <= pair_sum[16:1];
        end
        if (r_state == S_MUL_B) begin
            r_acc <= r_prod[24:0];
        end
        if (r_state == S_WSTART) begin
            r_neg <= wnum[25];
            if (wsum == '0) begin
                r_weighted <= r_mean;
            end
        end
        if (r_state == S_WDIV && div_stat.done) begin
            r_weighted <= r_neg ? ~div_quot[SAMPLE_BITS-1:0] : div_quot[SAMPLE_BITS-1:0];
        end
        if (r_state == S_GSTART) begin
            r_gain <= '0;
        end
        if (r_state == S_GDIV && div_stat.done) begin
            r_gain <= div_quot[VAR_BITS-1:0];
        end
        if (r_state == S_OUT && out_free) begin
            r_out.mean_value     <= r_mean;
            r_out.weighted_value <= r_weighted;
            r_out.filtered_value <= r_estimate;
        end
    end

    // Checks
    `TSKF_ASSERT_NXT(a_take_starts, i_clk, i_rst_n, in_take, r_state == S_MUL_A)
    `TSKF_ASSERT_IMP(a_var_bound, i_clk, i_rst_n, 1'b1, r_var <= GAIN_ONE)
    `TSKF_ASSERT_IMP(a_div_done_wait, i_clk, i_rst_n, div_stat.done, r_state == S_WDIV || r_state == S_GDIV)
    `TSKF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_state == S_OUT && !out_free, r_state == S_OUT)

endmodule

FILE: bench/two_sensor_kalman_fusion_tb.sv
`timescale 1ns / 1ps

module two_sensor_kalman_fusion_tb;
    import tskf_pkg::*;

    localparam int  CLK_HALF     = 2;
    localparam int  RESET_CYCLES = 6;
    localparam int  CYCLE_LIMIT  = 600000;
    localparam int  DRAIN_CYCLES = 150;
    localparam int  HOLD_CYCLES  = 400;
    localparam longint Q16_ONE   = 65536;
    localparam longint VAR_MASK  = 'h1FFFF;
    localparam longint SMP_MAX   = 32767;
    localparam longint SMP_MIN   = -32768;
    // index past the end of the register list
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_in_item                 i_in_data;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_out_item                o_out_data;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    // predictor state and register copies
    longint kf_estimate;
    longint kf_variance;
    longint cfg_weight_first;
    longint cfg_weight_second;
    longint cfg_noise_var;

    t_out_item pending_fusions[$];
    int        error_count = 0;
    int        cycle_count;
    int        send_idle_pct;
    int        out_stall_pct;
    logic      receiver_hold;
    event      hold_kick;

    two_sensor_kalman_fusion dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // timeout watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("two_sensor_kalman_fusion test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint floor_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint clamp_sample(input longint v);
        if (v > SMP_MAX) begin
            return SMP_MAX;
        end else if (v < SMP_MIN) begin
            return SMP_MIN;
        end
        return v;
    endfunction

    // Fuse one sample pair and advance the Kalman state
    function automatic t_out_item fuse_and_filter(input t_in_item item);
        longint    a;
        longint    b;
        longint    mean;
        longint    wsum;
        longint    weighted;
        longint    p;
        longint    denom;
        longint    gain;
        t_out_item res;
        a     = longint'($signed(item.sample_first));
        b     = longint'($signed(item.sample_second));
        mean  = clamp_sample(floor_quot(a + b, 2));
        wsum  = cfg_weight_first + cfg_weight_second;
        // both weights zero falls back to the plain mean
        if (wsum == 0) begin
            weighted = mean;
        end else begin
            weighted = clamp_sample(floor_quot(cfg_weight_first * a +
                                               cfg_weight_second * b, wsum));
        end
        // gain is zero when P + R is zero
        p     = kf_variance & VAR_MASK;
        denom = p + cfg_noise_var;
        gain  = 0;
        if (denom != 0) begin
            gain = (p * Q16_ONE) / denom;
        end
        if (gain > Q16_ONE) begin
            gain = Q16_ONE;
        end
        kf_estimate = clamp_sample(kf_estimate +
                                   floor_quot(gain * (weighted - kf_estimate), Q16_ONE));
        kf_variance = ((Q16_ONE - gain) * p / Q16_ONE) & VAR_MASK;
        res.mean_value     = mean[SAMPLE_BITS-1:0];
        res.weighted_value = weighted[SAMPLE_BITS-1:0];
        res.filtered_value = kf_estimate[SAMPLE_BITS-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Offer one sample pair, record its expected result on acceptance
    task automatic send_pair(input longint a, input longint b);
        t_in_item item;
        item.sample_first  = a[SAMPLE_BITS-1:0];
        item.sample_second = b[SAMPLE_BITS-1:0];
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_data  <= t_in_item'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_fusions.push_back(fuse_and_filter(item));
    endtask

    // Register write transaction; held until o_cfg_ready shows the block idle
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_WEIGHT_FIRST:   cfg_weight_first  = longint'(val[WEIGHT_BITS-1:0]);
            CFG_WEIGHT_SECOND:  cfg_weight_second = longint'(val[WEIGHT_BITS-1:0]);
            CFG_NOISE_VARIANCE: cfg_noise_var     = longint'(val[NOISE_BITS-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_fusions.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver stall, with the long hold-off layered on top
    always @(negedge i_clk) begin
        i_out_stall <= receiver_hold || ($urandom_range(99) < out_stall_pct);
    end

    // Long hold-off counter
    initial begin
        receiver_hold = 1'b0;
        forever begin
            @(hold_kick);
            @(posedge i_clk);
            receiver_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            receiver_hold = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    task automatic check_field(input string field, input t_sample want, input t_sample got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_fusions.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d %0d %0d", $time,
                         o_out_data.mean_value, o_out_data.weighted_value,
                         o_out_data.filtered_value);
                error_count++;
            end else begin
                want = pending_fusions.pop_front();
                check_field("mean_value", want.mean_value, o_out_data.mean_value);
                check_field("weighted_value", want.weighted_value, o_out_data.weighted_value);
                check_field("filtered_value", want.filtered_value, o_out_data.filtered_value);
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset register values with sample extremes and floor rounding
    task automatic test_reset_defaults();
        send_pair(0, 0);
        send_pair(SMP_MAX, SMP_MAX);
        send_pair(SMP_MIN, SMP_MIN);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair(-1, 0);
        send_pair(1, -2);
        send_pair(256, -256);
        send_pair(-3, 4);
        send_pair('h5555, -'h5556);
        drain_results();
    endtask

    // Out-of-list index, masked weights, both weights zero, extreme R
    task automatic test_register_masking();
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        write_reg(CFG_WEIGHT_FIRST, 16'hFF00);
        write_reg(CFG_WEIGHT_SECOND, 16'h00FF);
        send_pair(100, -200);
        send_pair(SMP_MIN, SMP_MAX);
        drain_results();
        write_reg(CFG_WEIGHT_SECOND, 16'h3C00);
        send_pair(-5, 2);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(7, 8);
        drain_results();
        write_reg(CFG_WEIGHT_FIRST, 16'h00FF);
        write_reg(CFG_WEIGHT_SECOND, 16'hA5FF);
        write_reg(CFG_NOISE_VARIANCE, 16'hFFFF);
        send_pair(-1, -2);
        send_pair(SMP_MAX, SMP_MAX - 1);
        send_pair(SMP_MIN, 1);
        drain_results();
    endtask

    // One random phase with its own register setting and idle profile
    task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
        longint a;
        longint b;
        int     kind;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_IDX_SPARE, 16'($urandom));
        end
        write_reg(CFG_WEIGHT_FIRST, 16'($urandom));
        write_reg(CFG_WEIGHT_SECOND, 16'($urandom));
        write_reg(CFG_NOISE_VARIANCE, 16'($urandom_range(65535, 16384)));
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            a    = longint'($signed(16'($urandom)));
            if (kind < 55) begin
                b = longint'($signed(16'($urandom)));
            end else if (kind < 85) begin
                // sensors roughly agreeing
                b = clamp_sample(a + longint'($urandom_range(512)) - 256);
            end else begin
                case ($urandom_range(4))
                    0: b = SMP_MIN;
                    1: b = -1;
                    2: b = 0;
                    3: b = 1;
                    default: b = SMP_MAX;
                endcase
                if ($urandom_range(1) == 1) begin
                    a = -b - 1;
                end
            end
            send_pair(a, b);
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        random_phase(250, 0, 0);
        random_phase(200, 88, 0);
        random_phase(200, 0, 88);
        random_phase(250, 9, 9);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        out_stall_pct = 0;
        -> hold_kick;
        for (int n = 0; n < 24; n++) begin
            send_pair(longint'($signed(16'($urandom))), longint'($signed(16'($urandom))));
        end
        drain_results();
    endtask

    // R = 0 drives P to zero, after which P + R is zero and the gain vanishes
    task automatic test_zero_gain();
        send_idle_pct = 0;
        out_stall_pct = 0;
        write_reg(CFG_NOISE_VARIANCE, 16'h0000);
        send_pair(1234, -4321);
        send_pair(SMP_MAX, SMP_MAX);
        send_pair(SMP_MIN, 0);
        send_pair(-77, 99);
        drain_results();
        write_reg(CFG_NOISE_VARIANCE, 16'hFFFF);
        send_pair(SMP_MAX, SMP_MIN);
        drain_results();
    endtask

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_in_data         = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        send_idle_pct     = 0;
        out_stall_pct     = 0;
        kf_estimate       = 0;
        kf_variance       = Q16_ONE;
        cfg_weight_first  = longint'(WEIGHT_FIRST_RST);
        cfg_weight_second = longint'(WEIGHT_SECOND_RST);
        cfg_noise_var     = longint'(NOISE_RST);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_masking();
        test_random_traffic();
        test_output_backpressure();
        test_zero_gain();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("two_sensor_kalman_fusion test passed");
        end else begin
            $display("two_sensor_kalman_fusion test failed");
        end
        $finish;
    end

endmodule
